@@ rtl/servo_duty_command_unit_defines.svh @@
// Assertion macros shared by the servo command unit checkers.
// No dependencies; take in by `include where assertions are written.
`ifndef SERVO_DUTY_COMMAND_UNIT_DEFINES_SVH
`define SERVO_DUTY_COMMAND_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDCU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sdcu_pkg.sv @@
// Types, codes and helper functions for the servo duty command unit.
// No dependencies; used by every other RTL file by scoped names.
package sdcu_pkg;

  localparam int NUM_SERVOS = 2;
  localparam int SERVO_IDX_W = $clog2(NUM_SERVOS);
  localparam int DUTY_W = 7;
  localparam int PULSE_W = 6;
  localparam int CFG_W = 8;
  localparam int AMOUNT_W = 8;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
  localparam logic [PULSE_W-1:0] PW_MIN = 6'd15;
  localparam logic [PULSE_W-1:0] PW_MAX = 6'd50;
  // floor(d * 35 / 100) == (d * 22939) >> 16 for d in 0..100
  localparam logic [15:0] DUTY_SCALE = 16'd22939;
  localparam int DUTY_SHIFT = 16;

  // servo that honors the automatic lock
  localparam logic [SERVO_IDX_W-1:0] LOCK_SERVO = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_OPEN_DUTY0   = 2'd0,
    REG_OPEN_DUTY1   = 2'd1,
    REG_CLOSED_DUTY0 = 2'd2,
    REG_CLOSED_DUTY1 = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_SET         = 3'd0,
    OP_INC         = 3'd1,
    OP_DEC         = 3'd2,
    OP_MAN_OPEN    = 3'd3,
    OP_MAN_CLOSED  = 3'd4,
    OP_AUTO_CTRL   = 3'd5,
    OP_AUTO_OPEN   = 3'd6,
    OP_AUTO_CLOSED = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MARK_CLOSED = 2'd0,
    MARK_OPEN   = 2'd1,
    MARK_NONE   = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_LOCKED  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [PULSE_W-1:0] pulse;
    mark_t              mark;
    logic               manual;
  } servo_state_t;

  // Clamp a signed duty request to 0..100.
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [9:0] req);
    logic [DUTY_W-1:0] res;
    if (req < 0) begin
      res = '0;
    end else if (req > $signed({3'b000, DUTY_FULL})) begin
      res = DUTY_FULL;
    end else begin
      res = req[DUTY_W-1:0];
    end
    return res;
  endfunction

  // Pulse width 15 + 35*d/100 through a reciprocal multiply.
  function automatic logic [PULSE_W-1:0] duty_to_pulse(input logic [DUTY_W-1:0] d);
    logic [21:0] prod;
    prod = 22'(d) * 22'(DUTY_SCALE);
    return PULSE_W'(prod[21:DUTY_SHIFT]) + PW_MIN;
  endfunction

endpackage

@@ rtl/sdcu_cmd_exec.sv @@
// Next-state logic for one servo: decodes a command and applies it.
// Depends on sdcu_pkg.
module sdcu_cmd_exec (
  input  sdcu_pkg::op_t                   op,
  input  logic [sdcu_pkg::AMOUNT_W-1:0]   amount,
  input  logic                            lock_en,    // servo honors the auto lock
  input  logic [sdcu_pkg::CFG_W-1:0]      open_duty,
  input  logic [sdcu_pkg::CFG_W-1:0]      closed_duty,
  input  sdcu_pkg::servo_state_t          cur,
  output sdcu_pkg::servo_state_t          nxt,
  output sdcu_pkg::status_t               status
);

  logic locked;
  logic signed [9:0] req;
  logic [sdcu_pkg::DUTY_W-1:0] duty_new;

  // manual ops refused on a servo that honors the lock while under auto control and parked open
  assign locked = lock_en && !cur.manual && (cur.mark == sdcu_pkg::MARK_OPEN) &&
                  (op == sdcu_pkg::OP_SET || op == sdcu_pkg::OP_INC ||
                   op == sdcu_pkg::OP_DEC || op == sdcu_pkg::OP_MAN_OPEN ||
                   op == sdcu_pkg::OP_MAN_CLOSED);

  always_comb begin
    unique case (op) inside
      sdcu_pkg::OP_SET: req = $signed({2'b00, amount});
      sdcu_pkg::OP_INC: req = $signed({3'b000, cur.duty}) + $signed({2'b00, amount});
      sdcu_pkg::OP_DEC: req = $signed({3'b000, cur.duty}) - $signed({2'b00, amount});
      sdcu_pkg::OP_MAN_OPEN, sdcu_pkg::OP_AUTO_OPEN: req = $signed({2'b00, open_duty});
      default: req = $signed({2'b00, closed_duty});
    endcase
  end

  assign duty_new = sdcu_pkg::clamp_duty(req);

  always_comb begin
    nxt = cur;
    status = sdcu_pkg::ST_APPLIED;
    if (locked) begin
      status = sdcu_pkg::ST_LOCKED;
    end else begin
      unique case (op) inside
        sdcu_pkg::OP_SET, sdcu_pkg::OP_INC, sdcu_pkg::OP_DEC: begin
          nxt.manual = 1'b1;
          nxt.duty = duty_new;
          nxt.pulse = sdcu_pkg::duty_to_pulse(duty_new);
          nxt.mark = sdcu_pkg::MARK_NONE;
        end
        sdcu_pkg::OP_MAN_OPEN: begin
          nxt.manual = 1'b1;
          nxt.duty = duty_new;
          nxt.pulse = sdcu_pkg::duty_to_pulse(duty_new);
          nxt.mark = sdcu_pkg::MARK_OPEN;
        end
        sdcu_pkg::OP_MAN_CLOSED: begin
          nxt.manual = 1'b1;
          nxt.duty = duty_new;
          nxt.pulse = sdcu_pkg::duty_to_pulse(duty_new);
          nxt.mark = sdcu_pkg::MARK_CLOSED;
        end
        sdcu_pkg::OP_AUTO_CTRL: begin
          nxt.manual = 1'b0;
        end
        sdcu_pkg::OP_AUTO_OPEN: begin
          nxt.duty = duty_new;
          nxt.pulse = sdcu_pkg::duty_to_pulse(duty_new);
          nxt.mark = sdcu_pkg::MARK_OPEN;
        end
        default: begin
          nxt.duty = duty_new;
          nxt.pulse = sdcu_pkg::duty_to_pulse(duty_new);
          nxt.mark = sdcu_pkg::MARK_CLOSED;
        end
      endcase
    end
  end

endmodule

@@ rtl/servo_duty_command_unit.sv @@
// Servo duty command unit: per-servo state file, command execution, result register.
// Depends on sdcu_pkg and sdcu_cmd_exec.
// Results are registered: a result is valid in the cycle after its command transfer.
// Throughput: 1 command per cycle while m_tready is high.
// Reset (rst, synchronous): servo state to duty 0, pulse 0, no mark, automatic;
//   config to open 100 / closed 0; result register empty.
module servo_duty_command_unit (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // op[2:0], servo[4:3], amount[12:5], zero pad
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // servo_out[1:0], pulse_width[7:2], duty_percent[14:8],
                                 // position_mark[16:15], manual_mode[17], status[19:18]
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  // configuration registers
  logic [sdcu_pkg::CFG_W-1:0] open_duty0;
  logic [sdcu_pkg::CFG_W-1:0] open_duty1;
  logic [sdcu_pkg::CFG_W-1:0] closed_duty0;
  logic [sdcu_pkg::CFG_W-1:0] closed_duty1;

  // per-servo state
  sdcu_pkg::servo_state_t servo_st [sdcu_pkg::NUM_SERVOS];

  // result register
  logic [1:0]                   servo_out;
  logic [sdcu_pkg::PULSE_W-1:0] pulse_width;
  logic [sdcu_pkg::DUTY_W-1:0]  duty_percent;
  sdcu_pkg::mark_t              position_mark;
  logic                         manual_mode;
  sdcu_pkg::status_t            status;

  // command fields
  sdcu_pkg::op_t                  cmd_op;
  logic [1:0]                     cmd_servo;
  logic [sdcu_pkg::AMOUNT_W-1:0]  cmd_amount;

  logic                               accept;
  logic                               servo_ok;
  logic [sdcu_pkg::SERVO_IDX_W-1:0]   idx;
  logic [sdcu_pkg::CFG_W-1:0]         sel_open;
  logic [sdcu_pkg::CFG_W-1:0]         sel_closed;
  sdcu_pkg::servo_state_t             cur_st;
  sdcu_pkg::servo_state_t             nxt_st;
  sdcu_pkg::status_t                  exec_status;

  assign cmd_op     = sdcu_pkg::op_t'(s_tdata[2:0]);
  assign cmd_servo  = s_tdata[4:3];
  assign cmd_amount = s_tdata[12:5];

  // result register frees in the same cycle it is taken
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign servo_ok = (32'(cmd_servo) < sdcu_pkg::NUM_SERVOS);
  assign idx      = cmd_servo[sdcu_pkg::SERVO_IDX_W-1:0];
  assign cur_st   = servo_st[idx];
  assign sel_open   = (idx == sdcu_pkg::LOCK_SERVO) ? open_duty1 : open_duty0;
  assign sel_closed = (idx == sdcu_pkg::LOCK_SERVO) ? closed_duty1 : closed_duty0;

  sdcu_cmd_exec u_exec (
    .op          (cmd_op),
    .amount      (cmd_amount),
    .lock_en     (idx == sdcu_pkg::LOCK_SERVO),
    .open_duty   (sel_open),
    .closed_duty (sel_closed),
    .cur         (cur_st),
    .nxt         (nxt_st),
    .status      (exec_status)
  );

  // config writes; the user must issue them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      open_duty0   <= 8'd100;
      open_duty1   <= 8'd100;
      closed_duty0 <= 8'd0;
      closed_duty1 <= 8'd0;
    end else if (cfg_we) begin
      unique case (sdcu_pkg::cfg_reg_t'(cfg_addr))
        sdcu_pkg::REG_OPEN_DUTY0:   open_duty0   <= cfg_wdata;
        sdcu_pkg::REG_OPEN_DUTY1:   open_duty1   <= cfg_wdata;
        sdcu_pkg::REG_CLOSED_DUTY0: closed_duty0 <= cfg_wdata;
        default:                    closed_duty1 <= cfg_wdata;
      endcase
    end
  end

  // state update; invalid servo numbers touch nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sdcu_pkg::NUM_SERVOS; i++) begin
        servo_st[i].duty   <= '0;
        servo_st[i].pulse  <= '0;
        servo_st[i].mark   <= sdcu_pkg::MARK_NONE;
        servo_st[i].manual <= 1'b0;
      end
    end else if (accept && servo_ok) begin
      servo_st[idx] <= nxt_st;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      servo_out <= cmd_servo;
      if (servo_ok) begin
        pulse_width   <= nxt_st.pulse;
        duty_percent  <= nxt_st.duty;
        position_mark <= nxt_st.mark;
        manual_mode   <= nxt_st.manual;
        status        <= exec_status;
      end else begin
        pulse_width   <= '0;
        duty_percent  <= '0;
        position_mark <= sdcu_pkg::MARK_NONE;
        manual_mode   <= 1'b0;
        status        <= sdcu_pkg::ST_INVALID;
      end
    end
  end

  assign m_tdata = {4'b0000, status, manual_mode, position_mark, duty_percent,
                    pulse_width, servo_out};

endmodule

@@ rtl/sdcu_port_checker.sv @@
// Port-level checker for servo_duty_command_unit, bound to the top level.
// Depends on sdcu_pkg and servo_duty_command_unit_defines.svh.
`include "servo_duty_command_unit_defines.svh"

module sdcu_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  logic bad_servo;
  logic is_invalid;
  logic neutral;
  logic in_range;
  logic stalled;

  assign bad_servo  = m_tdata[1];
  assign is_invalid = (m_tdata[19:18] == sdcu_pkg::ST_INVALID);
  // manual 0, mark none, duty 0, pulse 0
  assign neutral    = (m_tdata[17:2] == 16'h4000);
  assign in_range   = (m_tdata[14:8] <= 7'd100) && (m_tdata[7:2] <= 6'd50);
  assign stalled    = m_tvalid && !m_tready;

  // invalid status exactly when the servo number is out of range
  `SDCU_ASSERT_IMPLY(a_invalid_match, clk, rst, m_tvalid, bad_servo == is_invalid, "bad status")

  // invalid results carry a neutral state
  `SDCU_ASSERT_IMPLY(a_invalid_fields, clk, rst, m_tvalid && is_invalid, neutral, "not neutral")

  // duty and pulse stay in range
  `SDCU_ASSERT_IMPLY(a_ranges, clk, rst, m_tvalid, in_range, "duty or pulse out of range")

  // a stalled result holds
  `SDCU_ASSERT_NEXT(a_stall_hold, clk, rst, stalled, m_tvalid && $stable(m_tdata), "not held")

endmodule

bind servo_duty_command_unit sdcu_port_checker u_port_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for servo_duty_command_unit: directed table, then random command
// phases under several open/closed duty settings. Needs sdcu_pkg and the unit's RTL.
module tb_top;
  import sdcu_pkg::*;

  // one result transfer as seen on m_tdata
  typedef struct packed {
    logic [1:0] servo_out;
    logic [5:0] pulse;
    logic [6:0] duty;
    mark_t      mark;
    logic       manual;
    status_t    status;
  } servo_result_t;

  // row of the directed table; exp only means something when pinned is set
  typedef struct packed {
    op_t           op;
    logic [1:0]    servo;
    logic [7:0]    amount;
    logic          pinned;
    servo_result_t exp;
  } cmd_row_t;

  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 258;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // op[2:0], servo[4:3], amount[12:5], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // servo_out[1:0], pulse_width[7:2], duty_percent[14:8],
                               // position_mark[16:15], manual_mode[17], status[19:18]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;

  // no random idling on either side while set
  bit quiet = 1'b0;

  int mismatches = 0;
  servo_result_t pending_results[$];

  // shadow copy of the unit: per-servo state plus the four duty registers
  logic [6:0] duty_mem[2];
  logic [5:0] pulse_mem[2];
  mark_t      mark_mem[2];
  logic       manual_mem[2];
  logic [7:0] open_cfg[2];
  logic [7:0] closed_cfg[2];

  servo_duty_command_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Directed table. Pinned rows carry a result that is obvious from the spec
  // (reset state, clamping at the extremes, lock and bad-servo codes); the
  // rest are checked against the predictor. Config is at reset values here.
  cmd_row_t cmd_plan [28] = '{
    // bad servo index, any op
    '{OP_SET,         2'd2, 8'd255, 1'b1, '{2'd2, 6'd0,  7'd0,   MARK_NONE,   1'b0, ST_INVALID}},
    '{OP_AUTO_OPEN,   2'd3, 8'd0,   1'b1, '{2'd3, 6'd0,  7'd0,   MARK_NONE,   1'b0, ST_INVALID}},
    // untouched servo shows its reset state
    '{OP_AUTO_CTRL,   2'd0, 8'd0,   1'b1, '{2'd0, 6'd0,  7'd0,   MARK_NONE,   1'b0, ST_APPLIED}},
    // clamping of set, inc past 100, dec past 0
    '{OP_SET,         2'd0, 8'd255, 1'b1, '{2'd0, 6'd50, 7'd100, MARK_NONE,   1'b1, ST_APPLIED}},
    '{OP_SET,         2'd0, 8'd0,   1'b1, '{2'd0, 6'd15, 7'd0,   MARK_NONE,   1'b1, ST_APPLIED}},
    '{OP_INC,         2'd0, 8'd255, 1'b1, '{2'd0, 6'd50, 7'd100, MARK_NONE,   1'b1, ST_APPLIED}},
    '{OP_DEC,         2'd0, 8'd255, 1'b1, '{2'd0, 6'd15, 7'd0,   MARK_NONE,   1'b1, ST_APPLIED}},
    '{OP_SET,         2'd0, 8'd100, 1'b1, '{2'd0, 6'd50, 7'd100, MARK_NONE,   1'b1, ST_APPLIED}},
    '{OP_SET,         2'd0, 8'd101, 1'b1, '{2'd0, 6'd50, 7'd100, MARK_NONE,   1'b1, ST_APPLIED}},
    '{OP_SET,         2'd0, 8'd57,  1'b0, '0},
    '{OP_INC,         2'd0, 8'd3,   1'b0, '0},
    '{OP_DEC,         2'd0, 8'd200, 1'b1, '{2'd0, 6'd15, 7'd0,   MARK_NONE,   1'b1, ST_APPLIED}},
    '{OP_MAN_OPEN,    2'd0, 8'd0,   1'b1, '{2'd0, 6'd50, 7'd100, MARK_OPEN,   1'b1, ST_APPLIED}},
    '{OP_MAN_CLOSED,  2'd0, 8'd0,   1'b1, '{2'd0, 6'd15, 7'd0,   MARK_CLOSED, 1'b1, ST_APPLIED}},
    '{OP_AUTO_CTRL,   2'd0, 8'd0,   1'b1, '{2'd0, 6'd15, 7'd0,   MARK_CLOSED, 1'b0, ST_APPLIED}},
    '{OP_AUTO_OPEN,   2'd0, 8'd0,   1'b1, '{2'd0, 6'd50, 7'd100, MARK_OPEN,   1'b0, ST_APPLIED}},
    // servo 0 has no lock even when auto and open
    '{OP_SET,         2'd0, 8'd44,  1'b0, '0},
    // servo 1 auto open, then every manual op is refused
    '{OP_AUTO_OPEN,   2'd1, 8'd255, 1'b1, '{2'd1, 6'd50, 7'd100, MARK_OPEN,   1'b0, ST_APPLIED}},
    '{OP_SET,         2'd1, 8'd10,  1'b1, '{2'd1, 6'd50, 7'd100, MARK_OPEN,   1'b0, ST_LOCKED}},
    '{OP_INC,         2'd1, 8'd5,   1'b1, '{2'd1, 6'd50, 7'd100, MARK_OPEN,   1'b0, ST_LOCKED}},
    '{OP_DEC,         2'd1, 8'd5,   1'b1, '{2'd1, 6'd50, 7'd100, MARK_OPEN,   1'b0, ST_LOCKED}},
    '{OP_MAN_OPEN,    2'd1, 8'd0,   1'b1, '{2'd1, 6'd50, 7'd100, MARK_OPEN,   1'b0, ST_LOCKED}},
    '{OP_MAN_CLOSED,  2'd1, 8'd0,   1'b1, '{2'd1, 6'd50, 7'd100, MARK_OPEN,   1'b0, ST_LOCKED}},
    // auto closed releases the lock, manual open then takes over
    '{OP_AUTO_CLOSED, 2'd1, 8'd0,   1'b1, '{2'd1, 6'd15, 7'd0,   MARK_CLOSED, 1'b0, ST_APPLIED}},
    '{OP_MAN_OPEN,    2'd1, 8'd0,   1'b1, '{2'd1, 6'd50, 7'd100, MARK_OPEN,   1'b1, ST_APPLIED}},
    '{OP_SET,         2'd1, 8'd77,  1'b0, '0},
    '{OP_AUTO_CTRL,   2'd1, 8'd0,   1'b0, '0},
    '{OP_INC,         2'd3, 8'd255, 1'b1, '{2'd3, 6'd0,  7'd0,   MARK_NONE,   1'b0, ST_INVALID}}
  };

  // clamp a requested duty and store duty and pulse width for one servo
  function automatic void drive_duty(input logic idx, input int req);
    if (req < 0) begin
      pulse_mem[idx] = 6'd15;
      duty_mem[idx] = 7'd0;
    end else if (req > 100) begin
      pulse_mem[idx] = 6'd50;
      duty_mem[idx] = 7'd100;
    end else begin
      pulse_mem[idx] = 6'(35 * req / 100 + 15);
      duty_mem[idx] = 7'(req);
    end
  endfunction

  // execute one command on the shadow state, return the result it gives
  function automatic servo_result_t predict_servo_cmd(input op_t op, input logic [1:0] servo,
                                                     input logic [7:0] amount);
    servo_result_t r;
    logic idx;
    int opn;
    int cls;
    r = '0;
    r.servo_out = servo;
    if (servo > 2'd1) begin
      r.mark = MARK_NONE;
      r.status = ST_INVALID;
      return r;
    end
    idx = servo[0];
    opn = int'(open_cfg[idx]);
    cls = int'(closed_cfg[idx]);
    r.status = ST_APPLIED;
    // servo 1 under automatic control and parked open ignores manual ops
    if (op <= OP_MAN_CLOSED && idx == 1'b1 && !manual_mem[idx] && mark_mem[idx] == MARK_OPEN) begin
      r.status = ST_LOCKED;
    end else begin
      case (op)
        OP_SET: begin
          manual_mem[idx] = 1'b1;
          drive_duty(idx, int'(amount));
          mark_mem[idx] = MARK_NONE;
        end
        OP_INC: begin
          manual_mem[idx] = 1'b1;
          drive_duty(idx, int'(duty_mem[idx]) + int'(amount));
          mark_mem[idx] = MARK_NONE;
        end
        OP_DEC: begin
          manual_mem[idx] = 1'b1;
          drive_duty(idx, int'(duty_mem[idx]) - int'(amount));
          mark_mem[idx] = MARK_NONE;
        end
        OP_MAN_OPEN: begin
          manual_mem[idx] = 1'b1;
          drive_duty(idx, opn);
          mark_mem[idx] = MARK_OPEN;
        end
        OP_MAN_CLOSED: begin
          manual_mem[idx] = 1'b1;
          drive_duty(idx, cls);
          mark_mem[idx] = MARK_CLOSED;
        end
        OP_AUTO_CTRL: begin
          manual_mem[idx] = 1'b0;
        end
        OP_AUTO_OPEN: begin
          drive_duty(idx, opn);
          mark_mem[idx] = MARK_OPEN;
        end
        default: begin
          drive_duty(idx, cls);
          mark_mem[idx] = MARK_CLOSED;
        end
      endcase
    end
    r.pulse = pulse_mem[idx];
    r.duty = duty_mem[idx];
    r.mark = mark_mem[idx];
    r.manual = manual_mem[idx];
    return r;
  endfunction

  // Present one command and hold it until the transfer. tvalid is left high;
  // the caller lowers it when a gap follows.
  task automatic issue_cmd(input op_t op, input logic [1:0] servo, input logic [7:0] amount,
                           input logic pinned, input servo_result_t pinned_exp);
    servo_result_t pred;
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, amount, servo, op};
    do @(posedge clk); while (!s_tready);
    pred = predict_servo_cmd(op, servo, amount);
    pending_results.push_back(pinned ? pinned_exp : pred);
  endtask

  // random source gap between commands, after roughly 5 percent of them
  task automatic source_gap();
    if (!quiet && $urandom_range(99) < 5) begin
      s_tvalid <= 1'b0;
      s_tdata <= 16'($urandom);
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // stop sending and wait until every outstanding result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // one register write; cfg_we stays high for back-to-back writes
  task automatic put_reg(input cfg_reg_t r, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      REG_OPEN_DUTY0:   open_cfg[0] = v;
      REG_OPEN_DUTY1:   open_cfg[1] = v;
      REG_CLOSED_DUTY0: closed_cfg[0] = v;
      default:          closed_cfg[1] = v;
    endcase
  endtask

  // Sink: random backpressure, and every result transfer is checked
  // against the oldest expectation.
  always @(posedge clk) begin
    servo_result_t got;
    servo_result_t want;
    m_tready <= quiet || ($urandom_range(99) >= 7);
    if (!rst && m_tvalid && m_tready) begin
      got.servo_out = m_tdata[1:0];
      got.pulse = m_tdata[7:2];
      got.duty = m_tdata[14:8];
      got.mark = mark_t'(m_tdata[16:15]);
      got.manual = m_tdata[17];
      got.status = status_t'(m_tdata[19:18]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: tdata=%h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.servo_out !== want.servo_out || got.pulse !== want.pulse ||
            got.duty !== want.duty || got.mark !== want.mark ||
            got.manual !== want.manual || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp servo=%0d pw=%0d duty=%0d mark=%0d man=%0d st=%0d",
                     want.servo_out, want.pulse, want.duty, want.mark, want.manual,
                     want.status, "  got servo=%0d pw=%0d duty=%0d mark=%0d man=%0d st=%0d",
                     got.servo_out, got.pulse, got.duty, got.mark, got.manual, got.status);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] duties[4];
    op_t        op;
    logic [1:0] servo;
    logic [7:0] amount;

    // reset values of the shadow model
    for (int i = 0; i < 2; i++) begin
      duty_mem[i] = '0;
      pulse_mem[i] = '0;
      mark_mem[i] = MARK_NONE;
      manual_mem[i] = 1'b0;
      open_cfg[i] = 8'd100;
      closed_cfg[i] = 8'd0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset config
    foreach (cmd_plan[i]) begin
      issue_cmd(cmd_plan[i].op, cmd_plan[i].servo, cmd_plan[i].amount,
                cmd_plan[i].pinned, cmd_plan[i].exp);
      source_gap();
    end

    // random phases, each under its own duty setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      repeat (2) @(posedge clk);
      case (ph)
        0:       duties = '{8'd0, 8'd0, 8'd0, 8'd0};
        1:       duties = '{8'd255, 8'd255, 8'd255, 8'd255};
        2:       duties = '{8'd100, 8'd100, 8'd100, 8'd100};
        3:       duties = '{8'd101, 8'd50, 8'd0, 8'd255};
        default: begin
          foreach (duties[k]) duties[k] = 8'($urandom_range(0, 255));
        end
      endcase
      put_reg(REG_OPEN_DUTY0, duties[0]);
      put_reg(REG_OPEN_DUTY1, duties[1]);
      put_reg(REG_CLOSED_DUTY0, duties[2]);
      put_reg(REG_CLOSED_DUTY1, duties[3]);
      cfg_we <= 1'b0;
      // one phase runs with no idling on either side
      quiet = (ph == 2);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off mid-phase until the result side is empty
        if (n == PHASE_ITEMS / 2) drain();
        op = op_t'($urandom_range(0, 7));
        servo = ($urandom_range(9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
        case ($urandom_range(9))
          0, 1:    amount = 8'($urandom_range(0, 255));
          2: begin
            case ($urandom_range(3))
              0:       amount = 8'd0;
              1:       amount = 8'd255;
              2:       amount = 8'd100;
              default: amount = 8'd101;
            endcase
          end
          default: amount = 8'($urandom_range(0, 30));
        endcase
        issue_cmd(op, servo, amount, 1'b0, '0);
        source_gap();
      end
    end

    quiet = 1'b0;
    drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (pending_results.size() != 0)
        $display("%0d results never arrived", pending_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout, %0d results outstanding", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sdcu_pkg.sv
rtl/sdcu_cmd_exec.sv
rtl/servo_duty_command_unit.sv
rtl/sdcu_port_checker.sv
tb/tb_top.sv
